@@ rtl/core/fmpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fmpc_pkg;

  localparam int MAX_PATTERNS_DEF = 16;
  localparam int SET_SLOTS_DEF    = 4;
  localparam int OP_WIDTH_DEF     = 8;
  localparam int TAG_WIDTH_DEF    = 16;

  // fixed field widths of the stream words
  localparam int ENTRY_W       = 4;
  localparam int SLOT_W        = 2;
  localparam int SRC_CNT_W     = 4;
  localparam int CHECK_W       = 3;
  localparam int SET_SIZE_W    = 3;
  localparam int OP_VALUE_W    = 8;
  localparam int DTYPE_TAG_W   = 16;
  localparam int ARG_W         = 64;
  localparam int MATCH_INDEX_W = 4;
  localparam int CFG_COUNT_W   = 5;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 8;

  // register index of pattern_count on the apb port
  localparam logic REG_PATTERN_COUNT = 1'b0;

  typedef enum logic [1:0] {
    FUNC_RULE      = 2'd0,
    FUNC_OP_SLOT   = 2'd1,
    FUNC_TYPE_SLOT = 2'd2,
    FUNC_CLASSIFY  = 2'd3
  } func_t;

  // check_mask bits
  localparam int CHK_OP   = 0;
  localparam int CHK_TYPE = 1;
  localparam int CHK_ARG  = 2;

  typedef struct packed {
    logic rule_we;
    logic op_we;
    logic type_we;
  } fmpc_wr_t;

  typedef struct packed {
    logic valid;
    logic found;
  } fmpc_flags_t;

endpackage
`default_nettype wire

@@ rtl/core/fmpc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmpc_cell #(
  parameter int CELL_IDX  = 0,
  parameter int SET_SLOTS = fmpc_pkg::SET_SLOTS_DEF,
  parameter int OP_WIDTH  = fmpc_pkg::OP_WIDTH_DEF,
  parameter int TAG_WIDTH = fmpc_pkg::TAG_WIDTH_DEF,
  parameter int IDX_W     = 4,
  parameter int SZ_W      = 3
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  advance,
  input  wire                                  enabled,
  // pattern write side
  input  wire fmpc_pkg::fmpc_wr_t              wr,
  input  wire [SET_SLOTS-1:0]                  slot_we,
  input  wire [fmpc_pkg::SRC_CNT_W-1:0]        wr_need_count,
  input  wire                                  wr_exact,
  input  wire [fmpc_pkg::CHECK_W-1:0]          wr_checks,
  input  wire [SZ_W-1:0]                       wr_op_size,
  input  wire [SZ_W-1:0]                       wr_type_size,
  input  wire signed [fmpc_pkg::ARG_W-1:0]     wr_arg,
  input  wire [OP_WIDTH-1:0]                   wr_op,
  input  wire [TAG_WIDTH-1:0]                  wr_tag,
  // query from the left neighbor
  input  wire fmpc_pkg::fmpc_flags_t           flags_in,
  input  wire [IDX_W-1:0]                      idx_in,
  input  wire [fmpc_pkg::SRC_CNT_W-1:0]        q_cnt_in,
  input  wire [OP_WIDTH-1:0]                   q_op_in,
  input  wire [TAG_WIDTH-1:0]                  q_tag_in,
  input  wire signed [fmpc_pkg::ARG_W-1:0]     q_arg_in,
  input  wire                                  q_int_in,
  // query to the right neighbor
  output fmpc_pkg::fmpc_flags_t                flags_out,
  output logic [IDX_W-1:0]                     idx_out,
  output logic [fmpc_pkg::SRC_CNT_W-1:0]       q_cnt_out,
  output logic [OP_WIDTH-1:0]                  q_op_out,
  output logic [TAG_WIDTH-1:0]                 q_tag_out,
  output logic signed [fmpc_pkg::ARG_W-1:0]    q_arg_out,
  output logic                                 q_int_out
);

  logic [fmpc_pkg::SRC_CNT_W-1:0]   need_count;
  logic                             exact;
  logic [fmpc_pkg::CHECK_W-1:0]     checks;
  logic [SZ_W-1:0]                  op_size;
  logic [SZ_W-1:0]                  type_size;
  logic signed [fmpc_pkg::ARG_W-1:0] arg;
  logic [OP_WIDTH-1:0]              op_set   [SET_SLOTS];
  logic [TAG_WIDTH-1:0]             type_set [SET_SLOTS];

  logic cnt_ok;
  logic op_hit;
  logic type_hit;
  logic arg_ok;
  logic hit;

  always_ff @(posedge clk) begin
    if (wr.rule_we) begin
      need_count <= wr_need_count;
      exact      <= wr_exact;
      checks     <= wr_checks;
      op_size    <= wr_op_size;
      type_size  <= wr_type_size;
      arg        <= wr_arg;
    end
    for (int k = 0; k < SET_SLOTS; k++) begin
      if (wr.op_we && slot_we[k]) begin
        op_set[k] <= wr_op;
      end
      if (wr.type_we && slot_we[k]) begin
        type_set[k] <= wr_tag;
      end
    end
  end

  always_comb begin
    op_hit   = 1'b0;
    type_hit = 1'b0;
    for (int k = 0; k < SET_SLOTS; k++) begin
      if ((32'(k) < 32'(op_size)) && (op_set[k] == q_op_in)) begin
        op_hit = 1'b1;
      end
      if ((32'(k) < 32'(type_size)) && (type_set[k] == q_tag_in)) begin
        type_hit = 1'b1;
      end
    end
    cnt_ok = exact ? (q_cnt_in == need_count) : (q_cnt_in >= need_count);
    arg_ok = q_int_in && (q_arg_in == arg);
    hit    = flags_in.valid && !flags_in.found && enabled && cnt_ok
             && (!checks[fmpc_pkg::CHK_OP] || op_hit)
             && (!checks[fmpc_pkg::CHK_TYPE] || type_hit)
             && (!checks[fmpc_pkg::CHK_ARG] || arg_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else if (advance) begin
      flags_out.valid <= flags_in.valid;
      flags_out.found <= flags_in.found | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      idx_out   <= hit ? IDX_W'(CELL_IDX) : idx_in;
      q_cnt_out <= q_cnt_in;
      q_op_out  <= q_op_in;
      q_tag_out <= q_tag_in;
      q_arg_out <= q_arg_in;
      q_int_out <= q_int_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/first_match_pattern_classifier_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// first-match pattern classifier
// s_* carries one word per item; s_tuser selects the function (pattern rule
// write, op set slot write, type set slot write, classify). writes land in the
// addressed pattern cell in the cycle they are accepted and give no output.
// a classify word enters a chain of MAX_PATTERNS cells, one per pattern, and
// moves one cell per clock while the chain is not held; each cell checks its
// own pattern and the first hit is carried to the end. from the chain end the
// answer (match_found, match_index) moves into the output register and shows
// on m_*.
// one classify is in the chain at a time: s_tready drops from acceptance until
// its answer has moved into the output register; a write does not drop it. a
// new word is taken while the previous answer still waits on m_tready.
// if m_tready stays low and a second answer reaches the chain end, the chain
// holds in place until the output register frees.
// apb holds pattern_count at address 0; pready is always high.
// reset clears pattern_count, the chain and the output register; the pattern
// tables keep garbage until written and need no clearing pass.
module first_match_pattern_classifier_core #(
  parameter int MAX_PATTERNS = fmpc_pkg::MAX_PATTERNS_DEF,
  parameter int SET_SLOTS    = fmpc_pkg::SET_SLOTS_DEF,
  parameter int OP_WIDTH     = fmpc_pkg::OP_WIDTH_DEF,
  parameter int TAG_WIDTH    = fmpc_pkg::TAG_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // apb
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [2:0]                           paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input words
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // entry_index[3:0] slot_index[5:4] src_count[9:6] strict_len[10]
  // check_mask[13:11] op_set_size[16:14] type_set_size[19:17] op_value[27:20]
  // dtype_tag[43:28] arg_value[107:44] node_is_int[108] zero[111:109]
  input  wire  [fmpc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // func[1:0]
  input  wire  [1:0]                           s_tuser,
  // output words
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // match_found[0] match_index[4:1] zero[7:5]
  output logic [fmpc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int IDX_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERNS + 1);
  localparam int SZ_W  = $clog2(SET_SLOTS + 1);

  // input fields
  fmpc_pkg::func_t                       func;
  logic [fmpc_pkg::ENTRY_W-1:0]          entry_index;
  logic [fmpc_pkg::SLOT_W-1:0]           slot_index;
  logic [fmpc_pkg::SRC_CNT_W-1:0]        src_count;
  logic                                  strict_len;
  logic [fmpc_pkg::CHECK_W-1:0]          check_mask;
  logic [fmpc_pkg::SET_SIZE_W-1:0]       op_set_size;
  logic [fmpc_pkg::SET_SIZE_W-1:0]       type_set_size;
  logic [fmpc_pkg::OP_VALUE_W-1:0]       op_value;
  logic [fmpc_pkg::DTYPE_TAG_W-1:0]      dtype_tag;
  logic signed [fmpc_pkg::ARG_W-1:0]     arg_value;
  logic                                  node_is_int;

  assign func          = fmpc_pkg::func_t'(s_tuser[1:0]);
  assign entry_index   = s_tdata[3:0];
  assign slot_index    = s_tdata[5:4];
  assign src_count     = s_tdata[9:6];
  assign strict_len    = s_tdata[10];
  assign check_mask    = s_tdata[13:11];
  assign op_set_size   = s_tdata[16:14];
  assign type_set_size = s_tdata[19:17];
  assign op_value      = s_tdata[27:20];
  assign dtype_tag     = s_tdata[43:28];
  assign arg_value     = s_tdata[107:44];
  assign node_is_int   = s_tdata[108];

  logic [CNT_W-1:0]                pattern_count;
  logic [fmpc_pkg::CFG_COUNT_W-1:0] cfg_value;
  logic                            cfg_write;

  logic                            busy;
  logic                            accept;
  logic                            advance;
  logic                            res_load;
  logic                            res_valid;
  logic                            res_found;
  logic [IDX_W-1:0]                res_idx;

  logic [OP_WIDTH-1:0]             op_key;
  logic [OP_WIDTH-1:0]             q_op_key;
  logic [TAG_WIDTH-1:0]            tag_key;
  logic [SZ_W-1:0]                 op_size_clamped;
  logic [SZ_W-1:0]                 type_size_clamped;
  logic [SET_SLOTS-1:0]            slot_we;

  // chain links, link i feeds cell i
  fmpc_pkg::fmpc_flags_t           flags   [MAX_PATTERNS+1];
  logic [IDX_W-1:0]                idx     [MAX_PATTERNS+1];
  logic [fmpc_pkg::SRC_CNT_W-1:0]  q_cnt   [MAX_PATTERNS+1];
  logic [OP_WIDTH-1:0]             q_op    [MAX_PATTERNS+1];
  logic [TAG_WIDTH-1:0]            q_tag   [MAX_PATTERNS+1];
  logic signed [fmpc_pkg::ARG_W-1:0] q_arg [MAX_PATTERNS+1];
  logic                            q_int   [MAX_PATTERNS+1];

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[2] == fmpc_pkg::REG_PATTERN_COUNT);
  assign cfg_value = pwdata[fmpc_pkg::CFG_COUNT_W-1:0];
  assign prdata    = (paddr[2] == fmpc_pkg::REG_PATTERN_COUNT) ? 32'(pattern_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
    end else if (cfg_write) begin
      pattern_count <= (32'(cfg_value) > MAX_PATTERNS) ? CNT_W'(MAX_PATTERNS)
                                                        : CNT_W'(cfg_value);
    end
  end

  // handshake and chain control
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign advance  = !(flags[MAX_PATTERNS].valid && res_valid && !m_tready);
  assign res_load = flags[MAX_PATTERNS].valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (func == fmpc_pkg::FUNC_CLASSIFY)) begin
      busy <= 1'b1;
    end else if (res_load) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_found <= flags[MAX_PATTERNS].found;
      res_idx   <= flags[MAX_PATTERNS].found ? idx[MAX_PATTERNS] : '0;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {3'b000, fmpc_pkg::MATCH_INDEX_W'(res_idx), res_found};

  // write data shaping
  assign op_key  = OP_WIDTH'(op_value);
  assign tag_key = TAG_WIDTH'(dtype_tag);
  assign op_size_clamped   = (32'(op_set_size) > SET_SLOTS) ? SZ_W'(SET_SLOTS)
                                                            : SZ_W'(op_set_size);
  assign type_size_clamped = (32'(type_set_size) > SET_SLOTS) ? SZ_W'(SET_SLOTS)
                                                              : SZ_W'(type_set_size);
  // a node with no sources has first op zero
  assign q_op_key = (src_count == '0) ? '0 : op_key;

  always_comb begin
    for (int k = 0; k < SET_SLOTS; k++) begin
      slot_we[k] = (32'(slot_index) == k);
    end
  end

  // head of the chain
  assign flags[0].valid = accept && (func == fmpc_pkg::FUNC_CLASSIFY);
  assign flags[0].found = 1'b0;
  assign idx[0]         = '0;
  assign q_cnt[0]       = src_count;
  assign q_op[0]        = q_op_key;
  assign q_tag[0]       = tag_key;
  assign q_arg[0]       = arg_value;
  assign q_int[0]       = node_is_int;

  for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_cell
    fmpc_pkg::fmpc_wr_t wr;
    logic               sel;
    logic               enabled;

    assign sel        = accept && (32'(entry_index) == i);
    assign wr.rule_we = sel && (func == fmpc_pkg::FUNC_RULE);
    assign wr.op_we   = sel && (func == fmpc_pkg::FUNC_OP_SLOT);
    assign wr.type_we = sel && (func == fmpc_pkg::FUNC_TYPE_SLOT);
    assign enabled    = (i < 32'(pattern_count));

    fmpc_cell #(
      .CELL_IDX  (i),
      .SET_SLOTS (SET_SLOTS),
      .OP_WIDTH  (OP_WIDTH),
      .TAG_WIDTH (TAG_WIDTH),
      .IDX_W     (IDX_W),
      .SZ_W      (SZ_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .advance       (advance),
      .enabled       (enabled),
      .wr            (wr),
      .slot_we       (slot_we),
      .wr_need_count (src_count),
      .wr_exact      (strict_len),
      .wr_checks     (check_mask),
      .wr_op_size    (op_size_clamped),
      .wr_type_size  (type_size_clamped),
      .wr_arg        (arg_value),
      .wr_op         (op_key),
      .wr_tag        (tag_key),
      .flags_in      (flags[i]),
      .idx_in        (idx[i]),
      .q_cnt_in      (q_cnt[i]),
      .q_op_in       (q_op[i]),
      .q_tag_in      (q_tag[i]),
      .q_arg_in      (q_arg[i]),
      .q_int_in      (q_int[i]),
      .flags_out     (flags[i+1]),
      .idx_out       (idx[i+1]),
      .q_cnt_out     (q_cnt[i+1]),
      .q_op_out      (q_op[i+1]),
      .q_tag_out     (q_tag[i+1]),
      .q_arg_out     (q_arg[i+1]),
      .q_int_out     (q_int[i+1])
    );
  end

endmodule
`default_nettype wire

@@ bench/tb_first_match_pattern_classifier_core.sv @@
`timescale 1ns / 1ps
module tb_first_match_pattern_classifier_core;

  localparam int NPAT = fmpc_pkg::MAX_PATTERNS_DEF;
  localparam int NSLOT = fmpc_pkg::SET_SLOTS_DEF;
  localparam logic [2:0] COUNT_ADDR = {2'b00, fmpc_pkg::REG_PATTERN_COUNT} << 2;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int TAIL_CYCLES = 2 * NPAT + 8;
  localparam int STALL_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    fmpc_pkg::func_t func;
    bit [3:0] entry;
    bit [1:0] slot;
    bit [3:0] cnt;
    bit       strict;
    bit [2:0] chk;
    bit [2:0] op_sz;
    bit [2:0] ty_sz;
    bit [7:0] op;
    bit [15:0] tag;
    bit [63:0] arg;
    bit       arg_int;
  } cls_word_t;

  typedef struct {
    bit [3:0] need;
    bit       exact;
    bit [2:0] checks;
    int       op_size;
    int       type_size;
  } rule_entry_t;

  typedef struct packed {
    bit       found;
    bit [3:0] index;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic s_tvalid = 1'b0;
  wire s_tready;
  logic [fmpc_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  wire m_tvalid;
  logic m_tready = 1'b0;
  wire [fmpc_pkg::OUT_TDATA_W-1:0] m_tdata;

  // shadow of the pattern tables and the search count
  rule_entry_t rules [NPAT];
  bit [63:0] arg_store [NPAT];
  bit [7:0] op_set [NPAT][NSLOT];
  bit [15:0] type_set [NPAT][NSLOT];
  int pattern_limit = 0;

  cls_word_t word_q [$];
  answer_t answer_q [$];
  int errors = 0;
  bit in_fire = 1'b0;
  int src_idle = 14;
  int dst_idle = 75;
  int stall_req = 0;
  int stall_served = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  bit [7:0] op_pool [8];
  bit [15:0] tag_pool [8];
  bit [63:0] arg_pool [8];

  first_match_pattern_classifier_core uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  function automatic int clamp_size(bit [2:0] v);
    return (v > NSLOT) ? NSLOT : int'(v);
  endfunction

  function automatic bit set_holds(bit is_type, int p, int size, bit [15:0] key);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < size; k++) begin
      if (is_type ? (type_set[p][k] == key) : ({8'h00, op_set[p][k]} == key)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic bit rule_passes(int p, bit [3:0] cnt, bit [7:0] op, bit [15:0] tag,
                                     bit [63:0] arg, bit arg_int);
    bit ok;
    ok = 1'b1;
    if (rules[p].exact ? (cnt != rules[p].need) : (cnt < rules[p].need)) ok = 1'b0;
    if (rules[p].checks[fmpc_pkg::CHK_OP]
        && !set_holds(1'b0, p, rules[p].op_size, {8'h00, op}))
      ok = 1'b0;
    if (rules[p].checks[fmpc_pkg::CHK_TYPE] && !set_holds(1'b1, p, rules[p].type_size, tag))
      ok = 1'b0;
    if (rules[p].checks[fmpc_pkg::CHK_ARG] && (!arg_int || arg != arg_store[p])) ok = 1'b0;
    return ok;
  endfunction

  function automatic answer_t classify_node(cls_word_t w);
    answer_t r;
    bit [7:0] op;
    r = '0;
    // a node with no sources has no first op
    op = (w.cnt == 0) ? 8'h00 : w.op;
    for (int p = 0; p < pattern_limit; p++) begin
      if (!r.found && rule_passes(p, w.cnt, op, w.tag, w.arg, w.arg_int)) begin
        r.found = 1'b1;
        r.index = p[3:0];
      end
    end
    return r;
  endfunction

  function automatic bit [3:0] pick_count();
    return $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
  endfunction

  function automatic cls_word_t rand_word();
    cls_word_t w;
    int sel;
    sel = $urandom_range(99);
    w.func = (sel < 10) ? fmpc_pkg::FUNC_RULE : (sel < 22) ? fmpc_pkg::FUNC_OP_SLOT :
             (sel < 34) ? fmpc_pkg::FUNC_TYPE_SLOT : fmpc_pkg::FUNC_CLASSIFY;
    w.entry = 4'($urandom_range(15));
    w.slot = 2'($urandom_range(3));
    w.cnt = pick_count();
    w.strict = 1'($urandom_range(1));
    w.chk = 3'($urandom_range(7));
    w.op_sz = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    w.ty_sz = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    w.op = ($urandom_range(3) == 0) ? 8'($urandom) : op_pool[$urandom_range(7)];
    w.tag = ($urandom_range(3) == 0) ? 16'($urandom) : tag_pool[$urandom_range(7)];
    w.arg = ($urandom_range(3) == 0) ? {$urandom, $urandom} : arg_pool[$urandom_range(7)];
    w.arg_int = ($urandom_range(4) != 0);
    return w;
  endfunction

  function automatic cls_word_t rule_word(bit [3:0] entry, bit [3:0] cnt, bit strict,
                                          bit [2:0] chk, bit [2:0] osz, bit [2:0] tsz,
                                          bit [63:0] arg);
    cls_word_t w;
    w = rand_word();
    w.func = fmpc_pkg::FUNC_RULE;
    w.entry = entry;
    w.cnt = cnt;
    w.strict = strict;
    w.chk = chk;
    w.op_sz = osz;
    w.ty_sz = tsz;
    w.arg = arg;
    return w;
  endfunction

  function automatic cls_word_t slot_word(fmpc_pkg::func_t f, bit [3:0] entry, bit [1:0] slot,
                                          bit [7:0] op, bit [15:0] tag);
    cls_word_t w;
    w = rand_word();
    w.func = f;
    w.entry = entry;
    w.slot = slot;
    w.op = op;
    w.tag = tag;
    return w;
  endfunction

  function automatic cls_word_t node_word(bit [3:0] cnt, bit [7:0] op, bit [15:0] tag,
                                          bit [63:0] arg, bit arg_int);
    cls_word_t w;
    w = rand_word();
    w.func = fmpc_pkg::FUNC_CLASSIFY;
    w.cnt = cnt;
    w.op = op;
    w.tag = tag;
    w.arg = arg;
    w.arg_int = arg_int;
    return w;
  endfunction

  // wait until every queued word went in and every answer came out
  task automatic drain();
    while (word_q.size() != 0 || s_tvalid || answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // apb write, then read pattern_count back
  task automatic set_pattern_count(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] got;
    int v;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == COUNT_ADDR) begin
      v = int'(value & 32'd31);
      pattern_limit = (v > NPAT) ? NPAT : v;
    end
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= COUNT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got != 32'(pattern_limit)) begin
      errors++;
      $display("%0t: pattern_count readback expected %0d actual %0d", $time,
               pattern_limit, got);
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (word_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        s_tvalid <= 1'b1;
        s_tuser <= word_q[0].func;
        s_tdata <= {3'b000, word_q[0].arg_int, word_q[0].arg, word_q[0].tag, word_q[0].op,
                    word_q[0].ty_sz, word_q[0].op_sz, word_q[0].chk, word_q[0].strict,
                    word_q[0].cnt, word_q[0].slot, word_q[0].entry};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (stall_req != stall_served) begin
      stall_served = stall_req;
      stall_left = STALL_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // accepted words update the shadow tables or queue an answer
  always @(posedge clk) begin
    cls_word_t w;
    answer_t want;
    in_fire = s_tvalid && s_tready;
    if (!rst && in_fire) begin
      w = word_q.pop_front();
      case (w.func)
        fmpc_pkg::FUNC_RULE: begin
          rules[w.entry].need = w.cnt;
          rules[w.entry].exact = w.strict;
          rules[w.entry].checks = w.chk;
          rules[w.entry].op_size = clamp_size(w.op_sz);
          rules[w.entry].type_size = clamp_size(w.ty_sz);
          arg_store[w.entry] = w.arg;
        end
        fmpc_pkg::FUNC_OP_SLOT: op_set[w.entry][w.slot] = w.op;
        fmpc_pkg::FUNC_TYPE_SLOT: type_set[w.entry][w.slot] = w.tag;
        default: answer_q.push_back(classify_node(w));
      endcase
    end
    if (!rst && m_tvalid && m_tready) begin
      if (answer_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none actual %h", $time, m_tdata);
      end else begin
        want = answer_q.pop_front();
        if (m_tdata[0] !== want.found) begin
          errors++;
          $display("%0t: match_found expected %0d actual %0d", $time, want.found, m_tdata[0]);
        end
        if (m_tdata[4:1] !== want.index) begin
          errors++;
          $display("%0t: match_index expected %0d actual %0d", $time, want.index,
                   m_tdata[4:1]);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_cfg [8];
    cls_word_t w;
    phase_cfg = '{32'd16, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFE5, 32'd17, 32'd8, 32'd3};
    for (int i = 0; i < 8; i++) begin
      op_pool[i] = 8'($urandom);
      tag_pool[i] = 16'($urandom);
      arg_pool[i] = {$urandom, $urandom};
    end
    op_pool[0] = 8'h00;
    op_pool[1] = 8'hFF;
    tag_pool[0] = 16'h0000;
    tag_pool[1] = 16'hFFFF;
    arg_pool[0] = 64'h8000_0000_0000_0000;
    arg_pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
    arg_pool[2] = '1;
    arg_pool[3] = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    set_pattern_count(COUNT_ADDR, 32'd16);

    // load every pattern and slot so no classify ever reads an unwritten cell;
    // op check with an empty set keeps each loaded pattern from matching
    for (int p = 0; p < NPAT; p++) begin
      word_q.push_back(rule_word(4'(p), 4'd15, 1'b1, 3'b111, 3'd0, 3'd0, {$urandom, $urandom}));
      for (int s = 0; s < NSLOT; s++) begin
        word_q.push_back(slot_word(fmpc_pkg::FUNC_OP_SLOT, 4'(p), 2'(s), 8'($urandom),
                                   16'($urandom)));
        word_q.push_back(slot_word(fmpc_pkg::FUNC_TYPE_SLOT, 4'(p), 2'(s), 8'($urandom),
                                   16'($urandom)));
      end
    end

    // no sources forces op 0; oversized set saturates to all slots
    word_q.push_back(rule_word(4'd0, 4'd0, 1'b1, 3'b001, 3'd7, 3'd0, '0));
    word_q.push_back(slot_word(fmpc_pkg::FUNC_OP_SLOT, 4'd0, 2'd3, 8'h00, 16'hFFFF));
    word_q.push_back(slot_word(fmpc_pkg::FUNC_OP_SLOT, 4'd0, 2'd0, 8'hFF, 16'h0000));
    word_q.push_back(node_word(4'd0, 8'hAB, 16'h1234, '0, 1'b0));
    word_q.push_back(node_word(4'd1, 8'hFF, 16'h1234, '0, 1'b0));
    // at-least count with a type set
    word_q.push_back(rule_word(4'd0, 4'd1, 1'b0, 3'b010, 3'd0, 3'd4, '0));
    word_q.push_back(slot_word(fmpc_pkg::FUNC_TYPE_SLOT, 4'd0, 2'd0, 8'h00, 16'hFFFF));
    word_q.push_back(slot_word(fmpc_pkg::FUNC_TYPE_SLOT, 4'd0, 2'd3, 8'hFF, 16'h0000));
    word_q.push_back(node_word(4'd15, 8'h00, 16'hFFFF, '0, 1'b0));
    word_q.push_back(node_word(4'd1, 8'h00, 16'h0000, '0, 1'b1));
    word_q.push_back(node_word(4'd1, 8'h00, 16'h1234, '0, 1'b1));
    // argument check needs an integer with the same 64-bit value
    word_q.push_back(rule_word(4'd0, 4'd0, 1'b0, 3'b100, 3'd0, 3'd0, 64'h8000_0000_0000_0000));
    word_q.push_back(node_word(4'd3, 8'h00, 16'h0000, 64'h8000_0000_0000_0000, 1'b1));
    word_q.push_back(node_word(4'd3, 8'h00, 16'h0000, 64'h8000_0000_0000_0000, 1'b0));
    word_q.push_back(node_word(4'd3, 8'h00, 16'h0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
    // all checks on with an empty op set never matches
    word_q.push_back(rule_word(4'd0, 4'd0, 1'b0, 3'b111, 3'd0, 3'd4, '1));
    word_q.push_back(node_word(4'd0, 8'h00, 16'hFFFF, '1, 1'b1));
    // later patterns win only when earlier ones fail
    word_q.push_back(rule_word(4'd5, 4'd4, 1'b0, 3'b000, 3'd0, 3'd0, '0));
    word_q.push_back(node_word(4'd4, 8'h12, 16'h0000, '0, 1'b0));
    word_q.push_back(rule_word(4'd15, 4'd0, 1'b0, 3'b000, 3'd0, 3'd0, '0));
    word_q.push_back(node_word(4'd0, 8'h12, 16'h0000, '0, 1'b0));
    word_q.push_back(node_word(4'd15, 8'hFF, 16'hFFFF, '1, 1'b1));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 4) set_pattern_count(SPARE_ADDR, $urandom);
      set_pattern_count(COUNT_ADDR, phase_cfg[ph]);
      src_idle = (ph < 3) ? 14 : (ph < 6) ? 75 : 0;
      dst_idle = (ph < 3) ? 75 : (ph < 6) ? 14 : 0;
      for (int half = 0; half < 2; half++) begin
        for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
          w = rand_word();
          word_q.push_back(w);
        end
        // hold the output back long enough for the input side to back up
        if (ph == 6 && half == 0) stall_req++;
        drain();
      end
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
